/* rtl/mms_pkg.sv */
// Shared types and constants for the mouse motion smoother.
// Used by every module in the rtl folder; depends on nothing.
package mms_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;
	localparam int DECAY_WINDOW_DEF  = 128;

	localparam int MOTION_W = 16;
	localparam int HIST_W   = 17;
	localparam int TIME_W   = 32;
	localparam int SMOOTH_W = 16;

	// Q1.14 output: fraction bits, quotient bits and plus one
	localparam int Q_FRAC = 14;
	localparam int QUO_W  = 15;
	localparam logic signed [SMOOTH_W-1:0] Q_ONE = 16'sd16384;

	typedef struct packed {
		logic signed [MOTION_W-1:0] motion_x;
		logic signed [MOTION_W-1:0] motion_y;
		logic        [TIME_W-1:0]   timestamp;
	} motion_beat_t;

	typedef struct packed {
		logic signed [SMOOTH_W-1:0] smooth_x;
		logic signed [SMOOTH_W-1:0] smooth_y;
	} smooth_beat_t;

	typedef struct packed {
		logic signed [HIST_W-1:0] hx;
		logic signed [HIST_W-1:0] hy;
		logic        [TIME_W-1:0] htime;
	} sample_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_op_t;

endpackage

/* rtl/mouse_motion_smoother_top.sv */
// Mouse motion smoother top level: history cell chain, two MAC units, two Q1.14 converters.
// An input beat passes through the chain walk, then the conversion, then the hand-over to the output
// register; the conversion finishes early when both axes saturate.
// One item at a time: the next beat is accepted only once the result has been loaded into the
// output register, and a stalled output register holds the next result back.
// Reset zeroes the history and empties the output. Uses mms_pkg, mms_cell, mms_mac, mms_q14.
module mouse_motion_smoother_top #(
	parameter int HISTORY_DEPTH      = mms_pkg::HISTORY_DEPTH_DEF,
	parameter int DECAY_WINDOW_TICKS = mms_pkg::DECAY_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  motion_valid,
	output logic                  motion_stall,
	input  mms_pkg::motion_beat_t motion,
	output logic                  smooth_valid,
	input  logic                  smooth_stall,
	output mms_pkg::smooth_beat_t smooth
);

	localparam int DW  = $clog2(DECAY_WINDOW_TICKS + 1);
	localparam int PW  = mms_pkg::HIST_W + DW + 1;
	localparam int AW  = PW + HISTORY_DEPTH;
	localparam int CNTW = $clog2(HISTORY_DEPTH + 3);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_CONV = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                   state_q;
	logic [CNTW-1:0]              cnt_q;
	logic [mms_pkg::TIME_W-1:0]   now_q;
	logic                         smooth_valid_q;
	mms_pkg::smooth_beat_t        smooth_q;

	logic                         accept;
	logic                         reading;
	logic                         conv_start;
	mms_pkg::cell_op_t            op;
	mms_pkg::sample_t             fresh;
	mms_pkg::sample_t             chain [HISTORY_DEPTH];
	logic [mms_pkg::TIME_W-1:0]   age;
	logic                         in_window;

	logic signed [mms_pkg::HIST_W-1:0] hx_s1;
	logic signed [mms_pkg::HIST_W-1:0] hy_s1;
	logic [DW-1:0]                     d_s1;
	logic                              v_s1;

	logic signed [AW-1:0]                acc_x;
	logic signed [AW-1:0]                acc_y;
	logic                                busy_x;
	logic                                busy_y;
	logic signed [mms_pkg::SMOOTH_W-1:0] res_x;
	logic signed [mms_pkg::SMOOTH_W-1:0] res_y;

	assign motion_stall = (state_q != ST_IDLE);
	assign accept       = motion_valid & ~motion_stall;
	assign reading      = (state_q == ST_WALK) && (cnt_q < CNTW'(HISTORY_DEPTH));
	assign conv_start   = (state_q == ST_WALK) && (cnt_q == CNTW'(HISTORY_DEPTH + 2));

	assign op.shift  = accept;
	assign op.rotate = reading;

	// negate on entry; -32768 becomes +32768 in 17 bits
	assign fresh.hx    = -{motion.motion_x[mms_pkg::MOTION_W-1], motion.motion_x};
	assign fresh.hy    = -{motion.motion_y[mms_pkg::MOTION_W-1], motion.motion_y};
	assign fresh.htime = motion.timestamp;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		mms_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.newer  ((i == 0) ? fresh : chain[(i + HISTORY_DEPTH - 1) % HISTORY_DEPTH]),
			.older  (chain[(i + 1) % HISTORY_DEPTH]),
			.sample (chain[i])
		);
	end

	// the head cell presents newest first as the chain rotates
	assign age       = now_q - chain[0].htime;
	assign in_window = (age < mms_pkg::TIME_W'(DECAY_WINDOW_TICKS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= reading;
		end
	end

	always_ff @(posedge clk) begin
		hx_s1 <= chain[0].hx;
		hy_s1 <= chain[0].hy;
		d_s1  <= in_window ? DW'(DW'(DECAY_WINDOW_TICKS) - age[DW-1:0]) : '0;
	end

	mms_mac #(.DW(DW), .AW(AW)) u_mac_x (
		.clk (clk), .arst_n (arst_n), .clr (accept), .en (v_s1),
		.h (hx_s1), .d (d_s1), .acc (acc_x)
	);

	mms_mac #(.DW(DW), .AW(AW)) u_mac_y (
		.clk (clk), .arst_n (arst_n), .clr (accept), .en (v_s1),
		.h (hy_s1), .d (d_s1), .acc (acc_y)
	);

	mms_q14 #(.DEPTH(HISTORY_DEPTH), .WIN(DECAY_WINDOW_TICKS), .AW(AW)) u_q14_x (
		.clk (clk), .arst_n (arst_n), .start (conv_start), .acc (acc_x),
		.busy (busy_x), .res (res_x)
	);

	mms_q14 #(.DEPTH(HISTORY_DEPTH), .WIN(DECAY_WINDOW_TICKS), .AW(AW)) u_q14_y (
		.clk (clk), .arst_n (arst_n), .start (conv_start), .acc (acc_y),
		.busy (busy_y), .res (res_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						cnt_q   <= '0;
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (conv_start) state_q <= ST_CONV;
				end
				ST_CONV: if (!busy_x && !busy_y) state_q <= ST_OUT;
				ST_OUT:  if (!smooth_valid_q || !smooth_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= motion.timestamp;
		end
	end

	// output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && (!smooth_valid_q || !smooth_stall)) begin
			smooth_valid_q <= 1'b1;
		end else if (!smooth_stall) begin
			smooth_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!smooth_valid_q || !smooth_stall)) begin
			smooth_q.smooth_x <= res_x;
			smooth_q.smooth_y <= res_y;
		end
	end

	assign smooth_valid = smooth_valid_q;
	assign smooth       = smooth_q;

endmodule

/* rtl/mms_cell.sv */
// One history cell: holds a sample, shifts in from the newer side or
// rotates in from the older side. Depends on mms_pkg.
module mms_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mms_pkg::cell_op_t op,
	input  mms_pkg::sample_t  newer,
	input  mms_pkg::sample_t  older,
	output mms_pkg::sample_t  sample
);

	mms_pkg::sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (op.shift) begin
			sample_q <= newer;
		end else if (op.rotate) begin
			sample_q <= older;
		end
	end

	assign sample = sample_q;

endmodule

/* rtl/mms_mac.sv */
// Per-axis multiply and Horner accumulate: acc = 2*acc + h*d.
// Depends on mms_pkg.
module mms_mac #(
	parameter int DW = 8,
	parameter int AW = 36
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clr,
	input  logic                               en,
	input  logic signed [mms_pkg::HIST_W-1:0]  h,
	input  logic        [DW-1:0]               d,
	output logic signed [AW-1:0]               acc
);

	localparam int PW = mms_pkg::HIST_W + DW + 1;

	logic signed [PW-1:0] prod_s2;
	logic                 v_s2;
	logic signed [AW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= en & ~clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= h * $signed({1'b0, d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= (acc_q <<< 1) + {{(AW-PW){prod_s2[PW-1]}}, prod_s2};
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/mms_q14.sv */
// Per-axis conversion: floor(acc * 2^14 / DEN), saturated to plus/minus one,
// by a reciprocal multiply and a single correction step. Depends on mms_pkg.
module mms_q14 #(
	parameter int DEPTH = mms_pkg::HISTORY_DEPTH_DEF,
	parameter int WIN   = mms_pkg::DECAY_WINDOW_DEF,
	parameter int AW    = 36
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [AW-1:0]                 acc,
	output logic                                 busy,
	output logic signed [mms_pkg::SMOOTH_W-1:0]  res
);

	// DEN = WIN * DEPTH * 2^(DEPTH-1): the power of two goes as a shift,
	// WIN * DEPTH as a multiply by its scaled reciprocal
	localparam logic [63:0] WD    = 64'(WIN) * 64'(DEPTH);
	localparam logic [63:0] DEN   = WD << (DEPTH - 1);
	localparam int          DENW  = $clog2(DEN);
	localparam int          NW    = DENW + mms_pkg::Q_FRAC;
	localparam int          SW    = $clog2(WD) + mms_pkg::Q_FRAC;
	localparam int          CBW   = $clog2(WD + 64'd1);
	localparam int          RW    = CBW + 1;
	localparam logic [63:0] RECIP = (64'd1 << SW) / WD;
	localparam int          MW    = $clog2(RECIP + 64'd1);
	localparam int          QW    = mms_pkg::QUO_W;

	localparam logic [AW-1:0]  DEN_C    = AW'(DEN);
	localparam logic [MW-1:0]  RECIP_C  = MW'(RECIP);
	localparam logic [CBW-1:0] WD_C     = CBW'(WD);
	localparam logic [NW-1:0]  LOW_MASK = NW'((64'd1 << (DEPTH - 1)) - 64'd1);

	localparam logic [2:0] Q_IDLE = 3'd0;
	localparam logic [2:0] Q_PREP = 3'd1;
	localparam logic [2:0] Q_MUL  = 3'd2;
	localparam logic [2:0] Q_BACK = 3'd3;
	localparam logic [2:0] Q_FIX  = 3'd4;

	logic [2:0]                          state_q;
	logic                                neg_q;
	logic [AW-1:0]                       mag_q;
	logic [SW-1:0]                       num_q;
	logic                                sticky_q;
	logic [QW-1:0]                       quo_q;
	logic [RW-1:0]                       rem_q;
	logic signed [mms_pkg::SMOOTH_W-1:0] res_q;

	logic [AW-1:0]                abs_acc;
	logic [NW-1:0]                num_full;
	logic [SW+MW-1:0]             est;
	logic [QW+CBW-1:0]            back;
	logic [SW-1:0]                diff;
	logic                         ge;
	logic                         exact;
	logic [QW-1:0]                quo_fix;
	logic [mms_pkg::SMOOTH_W-1:0] quo_ext;

	assign abs_acc  = acc[AW-1] ? AW'(-acc) : AW'(acc);
	assign num_full = {mag_q[DENW-1:0], {mms_pkg::Q_FRAC{1'b0}}};
	// estimate is low by at most one
	assign est      = num_q * RECIP_C;
	assign back     = quo_q * WD_C;
	assign diff     = num_q - SW'(back);
	assign ge       = (rem_q >= RW'(WD_C));
	assign exact    = !sticky_q && ((rem_q == '0) || (rem_q == RW'(WD_C)));
	// negative values round away from zero in magnitude when inexact
	assign quo_fix  = quo_q + QW'(ge) + QW'(neg_q & ~exact);
	assign quo_ext  = {1'b0, quo_fix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
		end else begin
			unique case (state_q)
				Q_IDLE: if (start) state_q <= Q_PREP;
				Q_PREP: state_q <= (mag_q >= DEN_C) ? Q_IDLE : Q_MUL;
				Q_MUL:  state_q <= Q_BACK;
				Q_BACK: state_q <= Q_FIX;
				Q_FIX:  state_q <= Q_IDLE;
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			Q_IDLE: begin
				if (start) begin
					neg_q <= acc[AW-1];
					mag_q <= abs_acc;
				end
			end
			Q_PREP: begin
				if (mag_q >= DEN_C) begin
					res_q <= neg_q ? -mms_pkg::Q_ONE : mms_pkg::Q_ONE;
				end
				num_q    <= SW'(num_full >> (DEPTH - 1));
				sticky_q <= |(num_full & LOW_MASK);
			end
			Q_MUL: begin
				quo_q <= QW'(est >> SW);
			end
			Q_BACK: begin
				rem_q <= RW'(diff);
			end
			Q_FIX: begin
				res_q <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != Q_IDLE);
	assign res  = res_q;

endmodule
